// File: hdl/rppr_pkg.sv
// Shared types and constants for the rotary position pair rotator.
`default_nettype none

package rppr_pkg;

  // Default table geometry
  localparam int unsigned MAX_POSITIONS_DEF = 512;
  localparam int unsigned MAX_PAIRS_DEF     = 64;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Reset value of the pairs-in-use register
  localparam logic [6:0] PAIRS_RESET = 7'd64;

  // Request function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_ROTATE = 1'b1;

  // Input request
  typedef struct packed {
    logic               func;
    logic [8:0]         position;
    logic [5:0]         pair_index;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
  } rppr_in_t;

  // Result
  typedef struct packed {
    logic signed [15:0] rotated_first;
    logic signed [15:0] rotated_second;
    logic               saturated;
    logic               index_error;
  } rppr_out_t;

  // Classified operation carried from front to back (address travels beside it)
  typedef struct packed {
    logic               func;
    logic               bad;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
  } rppr_op_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } rppr_qstat_t;

endpackage

`default_nettype wire

// File: hdl/rppr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module rppr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: write or read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/rppr_front.sv
// Front end: config register, request intake, index check and table address.
`default_nettype none

module rppr_front
  import rppr_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int unsigned MAX_PAIRS     = MAX_PAIRS_DEF,
  localparam int unsigned Depth = MAX_POSITIONS * MAX_PAIRS,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [6:0]       cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rppr_in_t         in_req_i,
  input  wire rppr_qstat_t      qstat_i,
  output logic                  push_o,
  output rppr_op_t              push_op_o,
  output logic      [AddrW-1:0] push_addr_o
);

  // Reciprocal for position modulo: exact for 9-bit positions when modulus < 512
  localparam int unsigned RecipShift = 18;
  localparam int unsigned Recip =
    (MAX_POSITIONS >= 512) ? 0 : ((1 << RecipShift) / MAX_POSITIONS + 1);
  localparam logic [27:0] RecipC = 28'(Recip);

  logic [6:0]  pairs_q;
  logic        valid_q;
  rppr_in_t    req_q;
  logic [8:0]  quot_q;
  logic        bad_q;

  logic        accept;
  logic        pair_bad;
  logic [27:0] quot_prod;
  logic [31:0] addr_full;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= PAIRS_RESET;
    end else if (cfg_we_i) begin
      pairs_q <= cfg_wdata_i;
    end
  end

  // Index check against min(pairs in use, table pairs)
  assign pair_bad = (7'(in_req_i.pair_index) >= pairs_q)
                 || (32'(in_req_i.pair_index) >= 32'(MAX_PAIRS));

  // Quotient of position by the table row count
  assign quot_prod = 28'(in_req_i.position) * RecipC;

  assign in_ready_o = !valid_q || !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !qstat_i.full;

  // Intake register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_req_i;
      quot_q <= quot_prod[RecipShift+8:RecipShift];
      bad_q  <= pair_bad;
    end
  end

  // Row after wrap times row span, plus pair
  assign addr_full = 32'(req_q.position) * 32'(MAX_PAIRS)
                   - 32'(quot_q) * 32'(Depth)
                   + 32'(req_q.pair_index);

  assign push_addr_o    = addr_full[AddrW-1:0];
  assign push_op_o.func = req_q.func;
  assign push_op_o.bad  = bad_q;
  assign push_op_o.x0   = req_q.first_value;
  assign push_op_o.x1   = req_q.second_value;

endmodule

`default_nettype wire

// File: hdl/rppr_queue.sv
// Small flop-based queue between the front and back ends.
`default_nettype none

module rppr_queue
  import rppr_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output rppr_qstat_t           stat_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (32'(p) == DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign pop_data_o   = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rppr_back.sv
// Back end: table access, products, rounding, saturation and result register.
`default_nettype none

module rppr_back
  import rppr_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int unsigned MAX_PAIRS     = MAX_PAIRS_DEF,
  localparam int unsigned Depth = MAX_POSITIONS * MAX_PAIRS,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rppr_qstat_t      qstat_i,
  input  wire rppr_op_t         op_i,
  input  wire logic [AddrW-1:0] addr_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rppr_out_t             out_rsp_o
);

  logic        en1, en2, en3;
  logic        ram_en;
  logic [31:0] ram_rdata;

  logic               v1_q, v2_q, v3_q;
  logic signed [15:0] x0_1_q, x1_1_q;
  logic               bad1_q, bad2_q;
  logic signed [15:0] cos_v, sin_v;
  logic signed [31:0] pxc_q, pxs_q, pyc_q, pys_q;
  logic signed [32:0] sum0, sum1;
  logic [16:0]        rs0, rs1;
  rppr_out_t          rsp_q;

  // Round half up at bit 15, clip to 16 bits; bit 16 flags a clip
  function automatic logic [16:0] round_sat(input logic signed [32:0] sum);
    logic signed [33:0] biased;
    logic signed [18:0] shifted;
    biased  = 34'(sum) + 34'sd16384;
    shifted = biased[33:15];
    if (shifted > 19'sd32767) begin
      return {1'b1, 16'h7FFF};
    end else if (shifted < -19'sd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, shifted[15:0]};
  endfunction

  // Elastic stage enables
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pop_o  = !qstat_i.empty && en1;
  assign ram_en = pop_o && !op_i.bad;

  // Angle table: cosine high, sine low
  rppr_ram #(
    .WIDTH (32),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (op_i.func == FUNC_WRITE),
    .addr_i  (addr_i),
    .wdata_i ({op_i.x0, op_i.x1}),
    .rdata_o (ram_rdata)
  );

  assign cos_v = ram_rdata[31:16];
  assign sin_v = ram_rdata[15:0];

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= pop_o && (op_i.func == FUNC_ROTATE);
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Table read stage: carry the element pair
  always_ff @(posedge clk_i) begin
    if (en1 && pop_o) begin
      x0_1_q <= op_i.x0;
      x1_1_q <= op_i.x1;
      bad1_q <= op_i.bad;
    end
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pxc_q  <= x0_1_q * cos_v;
      pys_q  <= x1_1_q * sin_v;
      pxs_q  <= x0_1_q * sin_v;
      pyc_q  <= x1_1_q * cos_v;
      bad2_q <= bad1_q;
    end
  end

  // Sums, rounding and saturation into the result register
  assign sum0 = 33'(pxc_q) - 33'(pys_q);
  assign sum1 = 33'(pxs_q) + 33'(pyc_q);
  assign rs0  = round_sat(sum0);
  assign rs1  = round_sat(sum1);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      if (bad2_q) begin
        rsp_q.rotated_first  <= '0;
        rsp_q.rotated_second <= '0;
        rsp_q.saturated      <= 1'b0;
        rsp_q.index_error    <= 1'b1;
      end else begin
        rsp_q.rotated_first  <= rs0[15:0];
        rsp_q.rotated_second <= rs1[15:0];
        rsp_q.saturated      <= rs0[16] | rs1[16];
        rsp_q.index_error    <= 1'b0;
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// File: hdl/rotary_position_pair_rotator.sv
// Top level of the rotary position pair rotator.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_wdata_i (pairs in use)
//   in        in         in_valid_i / in_ready_o   in_req_i  (rppr_in_t)
//   out       out        out_valid_o / out_ready_i out_rsp_o (rppr_out_t)
//
// One request per cycle sustained while the output takes results; a rotate request's result
// passes the intake register, then the queue, table read, products and result register.
// Table writes and rejected writes give no result. The single-port angle table
// takes one access per cycle, which sets the rate.
// Reset clears control state only; table entries are undefined until written.
// A stall on the output fills the back pipeline, then the queue, then the intake.
`default_nettype none

module rotary_position_pair_rotator
  import rppr_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int unsigned MAX_PAIRS     = MAX_PAIRS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire rppr_in_t   in_req_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output rppr_out_t       out_rsp_o
);

  localparam int unsigned Depth  = MAX_POSITIONS * MAX_PAIRS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntryW = $bits(rppr_op_t) + AddrW;

  logic              push, pop;
  rppr_op_t          push_op, pop_op;
  logic [AddrW-1:0]  push_addr, pop_addr;
  logic [EntryW-1:0] pop_data;
  rppr_qstat_t       qstat;

  // Intake and classification
  rppr_front #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_PAIRS     (MAX_PAIRS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_op_o   (push_op),
    .push_addr_o (push_addr)
  );

  // Decoupling queue
  rppr_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_op, push_addr}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  assign pop_op   = pop_data[EntryW-1:AddrW];
  assign pop_addr = pop_data[AddrW-1:0];

  // Execution
  rppr_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_PAIRS     (MAX_PAIRS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .op_i        (pop_op),
    .addr_i      (pop_addr),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the rotary position pair rotator: random and directed requests, scoreboard check.
module tb;
  import rppr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 80;
  localparam int MAX_REPORTS  = 60;

  // Predicts rotation results from its own copy of the angle table and pair limit
  class rotation_scoreboard;
    logic [31:0] angle_tbl [int];
    int          written_keys[$];
    rppr_out_t   expected_q[$];
    logic [6:0]  pairs_in_use;
    int          errors;

    function new();
      pairs_in_use = PAIRS_RESET;
      errors = 0;
    endfunction

    function int pair_limit();
      return (pairs_in_use > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : int'(pairs_in_use);
    endfunction

    function void report(string name, logic signed [31:0] e, logic signed [31:0] a);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
    endfunction

    // Round half up at bit 15 (floor shift), then clip to 16 bits
    function logic [15:0] round_clip(longint sum, inout bit clipped);
      longint t;
      t = (sum + 16384) >>> 15;
      if (t > 32767) begin
        t = 32767;
        clipped = 1'b1;
      end else if (t < -32768) begin
        t = -32768;
        clipped = 1'b1;
      end
      return t[15:0];
    endfunction

    // Accepted request: update table on write, queue expected result on rotate
    function void note_request(rppr_in_t r);
      int        key;
      bit        bad;
      bit        clipped;
      longint    c, s, x0, x1;
      rppr_out_t res;
      key = int'(r.position) * MAX_PAIRS_DEF + int'(r.pair_index);
      bad = int'(r.pair_index) >= pair_limit();
      if (r.func == FUNC_WRITE) begin
        if (!bad) begin
          if (!angle_tbl.exists(key)) written_keys.push_back(key);
          angle_tbl[key] = {r.first_value, r.second_value};
        end
        return;
      end
      res = '0;
      if (bad) begin
        res.index_error = 1'b1;
      end else begin
        c  = $signed(angle_tbl[key][31:16]);
        s  = $signed(angle_tbl[key][15:0]);
        x0 = $signed(r.first_value);
        x1 = $signed(r.second_value);
        clipped = 1'b0;
        res.rotated_first  = round_clip(x0 * c - x1 * s, clipped);
        res.rotated_second = round_clip(x0 * s + x1 * c, clipped);
        res.saturated      = clipped;
      end
      expected_q.push_back(res);
    endfunction

    // Accepted result: compare field by field with the oldest expectation
    function void check_result(rppr_out_t got);
      rppr_out_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected, expected nothing actual %h", $time, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.rotated_first !== exp.rotated_first)
        report("rotated_first", exp.rotated_first, got.rotated_first);
      if (got.rotated_second !== exp.rotated_second)
        report("rotated_second", exp.rotated_second, got.rotated_second);
      if (got.saturated !== exp.saturated)
        report("saturated", exp.saturated, got.saturated);
      if (got.index_error !== exp.index_error)
        report("index_error", exp.index_error, got.index_error);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  rppr_in_t   in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rppr_out_t  out_rsp_o;

  rotation_scoreboard sb;
  int unsigned cycle_count;
  bit sender_idle;
  bit receiver_idle;
  bit hold_off_req;

  rotary_position_pair_rotator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Handshake monitor and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
    end
  end

  // Result receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    bit          hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 7) : 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [15:0] rand_q15();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 63) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rppr_in_t make_req(logic f, int pos, int pair, int a, int b);
    rppr_in_t r;
    r.func         = f;
    r.position     = pos[8:0];
    r.pair_index   = pair[5:0];
    r.first_value  = a[15:0];
    r.second_value = b[15:0];
    return r;
  endfunction

  // Random request: in-range rotates only hit written entries; some use an out-of-range pair
  function automatic rppr_in_t pick_request(output bit ignored);
    rppr_in_t r;
    int       lim;
    int       roll;
    int       key;
    bit       found;
    lim  = sb.pair_limit();
    roll = $urandom_range(0, 99);
    r = make_req(FUNC_WRITE, $urandom_range(0, 511), 0, rand_q15(), rand_q15());
    ignored = 1'b0;
    found = 1'b0;
    key = 0;
    if (roll >= 45 && sb.written_keys.size() > 0) begin
      for (int i = 0; i < 8 && !found; i++) begin
        key = sb.written_keys[$urandom_range(0, sb.written_keys.size() - 1)];
        if (key % MAX_PAIRS_DEF < lim) found = 1'b1;
      end
    end
    if (found) begin
      r.func       = FUNC_ROTATE;
      r.position   = 9'(key / MAX_PAIRS_DEF);
      r.pair_index = 6'(key % MAX_PAIRS_DEF);
    end else if (lim == 0 || (lim < MAX_PAIRS_DEF && roll < 15)) begin
      // out-of-range pair index
      r.func       = ($urandom_range(0, 2) == 0) ? FUNC_WRITE : FUNC_ROTATE;
      r.pair_index = 6'($urandom_range(lim, MAX_PAIRS_DEF - 1));
      ignored      = (r.func == FUNC_WRITE);
    end else begin
      r.pair_index = 6'($urandom_range(0, lim - 1));
    end
    return r;
  endfunction

  // Offer one request; valid stays high after acceptance until the next call
  task automatic send_request(rppr_in_t req, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Sender pause: wait for every expected result, then let writes drain
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pairs(logic [6:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.pairs_in_use = value;
  endtask

  task automatic run_phase(int count);
    rppr_in_t req;
    bit       ignored;
    int       n;
    n = 0;
    while (n < count) begin
      req = pick_request(ignored);
      send_request(req, sender_idle ? $urandom_range(0, 7) : 0);
      if (!ignored) n++;
    end
    stop_requests();
    wait_idle();
  endtask

  // Main sequence
  initial begin : stimulus
    rppr_in_t   directed[$];
    logic [6:0] phase_cfg[8];
    sb = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_off_req  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset pair limit: extremes, rounding, write-then-read back to back
    directed = '{
      make_req(FUNC_WRITE,  0,   0,  32767,      0),
      make_req(FUNC_ROTATE, 0,   0,  32767, -32768),
      make_req(FUNC_WRITE,  511, 63, -32768, -32768),
      make_req(FUNC_ROTATE, 511, 63, -32768, -32768),
      make_req(FUNC_ROTATE, 511, 63,  32767, -32768),
      make_req(FUNC_WRITE,  341, 42,      1,     -1),
      make_req(FUNC_ROTATE, 341, 42,  16384,      0),
      make_req(FUNC_ROTATE, 341, 42, -16384,      0),
      make_req(FUNC_ROTATE, 341, 42,  16383,  16385),
      make_req(FUNC_WRITE,  170, 21,  32767,  32767),
      make_req(FUNC_ROTATE, 170, 21,  32767,  32767),
      make_req(FUNC_ROTATE, 170, 21,      0,      0),
      make_req(FUNC_WRITE,  5,   7,  23170,  23170),
      make_req(FUNC_ROTATE, 5,   7,  -1000,  30000),
      make_req(FUNC_WRITE,  5,   7, -23170,  -5000),
      make_req(FUNC_ROTATE, 5,   7,  -1000,  30000)
    };
    foreach (directed[i]) send_request(directed[i], 0);
    stop_requests();
    wait_idle();

    // Directed, one pair in use: ignored write, error rotates
    write_pairs(7'd1);
    directed = '{
      make_req(FUNC_WRITE,  3,   1,  1234,  -4321),
      make_req(FUNC_ROTATE, 3,   1,  1234,  -4321),
      make_req(FUNC_ROTATE, 511, 63, -32768, 32767),
      make_req(FUNC_WRITE,  3,   0, -12000,  9000),
      make_req(FUNC_ROTATE, 3,   0,  20000, -20000)
    };
    foreach (directed[i]) send_request(directed[i], 0);
    stop_requests();
    wait_idle();

    // Random phases over several pair limits
    phase_cfg = '{7'd0, 7'd127, 7'd64, 7'd1, 7'($urandom_range(2, 63)), 7'd65,
                  7'($urandom_range(1, 64)), 7'd64};
    foreach (phase_cfg[i]) begin
      write_pairs(phase_cfg[i]);
      sender_idle   = !(i == 2 || i == 6);
      receiver_idle = (i != 6);
      // block fills up while the receiver holds off
      if (i == 2) hold_off_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
hdl/rppr_pkg.sv
hdl/rppr_ram.sv
hdl/rppr_front.sv
hdl/rppr_queue.sv
hdl/rppr_back.sv
hdl/rotary_position_pair_rotator.sv
tb/tb.sv
